// ===== design/tsd_pkg.sv =====
// ----------------------------------------------------------------------------
// TLV stream deframer package
// Shared types and constants for the TLV deframer: record type codes, kind
// codes, parse phases and the result word layout.
// ----------------------------------------------------------------------------
package tsd_pkg;

  localparam logic [15:0] TYPE_IP_CLIENT  = 16'h000B;
  localparam logic [15:0] TYPE_MAC_HEADER = 16'h000C;
  localparam logic [15:0] TYPE_BUFFER     = 16'h000D;

  localparam logic [1:0] KIND_MAC_HEADER = 2'd0;
  localparam logic [1:0] KIND_IP_CLIENT  = 2'd1;
  localparam logic [1:0] KIND_BUFFER     = 2'd2;

  typedef enum logic [4:0] {
    PH_TYPE_HI = 5'b00001,
    PH_TYPE_LO = 5'b00010,
    PH_LEN_HI  = 5'b00100,
    PH_LEN_LO  = 5'b01000,
    PH_VALUE   = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [7:0]  value_byte;
    logic [15:0] value_offset;
    logic        value_last;
    logic        truncated;
  } result_t;

  function automatic logic is_emitted(input logic [15:0] rtype);
    return (rtype == TYPE_MAC_HEADER) || (rtype == TYPE_IP_CLIENT) ||
           (rtype == TYPE_BUFFER);
  endfunction

  function automatic logic [1:0] kind_of(input logic [15:0] rtype);
    logic [1:0] k;
    k = KIND_MAC_HEADER;
    if (rtype == TYPE_IP_CLIENT) begin
      k = KIND_IP_CLIENT;
    end else if (rtype == TYPE_BUFFER) begin
      k = KIND_BUFFER;
    end
    return k;
  endfunction

endpackage

// ===== design/tsd_stream_ifs.sv =====
// ----------------------------------------------------------------------------
// TLV stream deframer channels
// Valid/ready channels for the incoming byte stream and the outgoing value
// words.
// ----------------------------------------------------------------------------
interface tsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface tsd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  record_kind;
  logic [7:0]  value_byte;
  logic [15:0] value_offset;
  logic        value_last;
  logic        truncated;

  modport source (output valid, output record_kind, output value_byte,
                  output value_offset, output value_last, output truncated,
                  input ready);
  modport sink (input valid, input record_kind, input value_byte,
                input value_offset, input value_last, input truncated,
                output ready);
endinterface

// ===== design/tlv_stream_deframer_top.sv =====
// ----------------------------------------------------------------------------
// TLV stream deframer
// Parses a byte-serial type-length-value stream and emits the value bytes of
// MAC header, IP client and payload records with kind, offset and last mark.
// ----------------------------------------------------------------------------
// A stream that ends inside a record yields a word marked truncated. Each result
// word is loaded into the result register once that register is free.
// Throughput: one byte per cycle while the result register is free, set by the
// single parse step between the input register and the result register.
// Reset: synchronous rst empties both registers and returns the parser to the
// start of a record with all counters at zero.
module tlv_stream_deframer_top (
  input  logic       clk,
  input  logic       rst,
  tsd_in_if.sink     stream,
  tsd_out_if.source  record
);

  logic             held_valid;
  logic [7:0]       held_byte;
  logic             held_eos;
  logic             out_free;
  logic             advance;
  logic             emit;
  tsd_pkg::result_t result;

  assign advance = held_valid && out_free;

  tsd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .stream     (stream),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte),
    .held_eos   (held_eos)
  );

  tsd_parse_core u_parse_core (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .data_byte     (held_byte),
    .end_of_stream (held_eos),
    .emit          (emit),
    .result        (result)
  );

  tsd_out_reg u_out_reg (
    .clk    (clk),
    .rst    (rst),
    .load   (advance && emit),
    .result (result),
    .free   (out_free),
    .record (record)
  );

endmodule

// ===== design/tsd_in_reg.sv =====
// ----------------------------------------------------------------------------
// TLV deframer input register
// Captures one stream word per cycle while the parser keeps consuming, and
// holds each word until the parser consumes it.
// ----------------------------------------------------------------------------
module tsd_in_reg (
  input  logic       clk,
  input  logic       rst,
  tsd_in_if.sink     stream,
  input  logic       advance,
  output logic       held_valid,
  output logic [7:0] held_byte,
  output logic       held_eos
);

  logic accept;

  assign stream.ready = !held_valid || advance;
  assign accept       = stream.valid && stream.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_byte <= stream.data_byte;
      held_eos  <= stream.end_of_stream;
    end
  end

endmodule

// ===== design/tsd_parse_core.sv =====
// ----------------------------------------------------------------------------
// TLV deframer parse core
// Tracks the header phase, record type and value counters, and forms the
// result word for each value byte of an emitted record or a truncation.
// ----------------------------------------------------------------------------
module tsd_parse_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       data_byte,
  input  logic             end_of_stream,
  output logic             emit,
  output tsd_pkg::result_t result
);

  tsd_pkg::phase_t phase, phase_next;
  logic [15:0] record_type, record_type_next;
  logic [15:0] bytes_remaining, bytes_remaining_next;
  logic [15:0] byte_position, byte_position_next;

  always_comb begin
    phase_next           = phase;
    record_type_next     = record_type;
    bytes_remaining_next = bytes_remaining;
    byte_position_next   = byte_position;
    emit                 = 1'b0;
    result               = '0;

    unique case (phase)
      tsd_pkg::PH_TYPE_LO: begin
        record_type_next = {record_type[15:8], data_byte};
        phase_next       = tsd_pkg::PH_LEN_HI;
      end
      tsd_pkg::PH_LEN_HI: begin
        bytes_remaining_next = {data_byte, 8'h00};
        phase_next           = tsd_pkg::PH_LEN_LO;
      end
      tsd_pkg::PH_LEN_LO: begin
        bytes_remaining_next = {bytes_remaining[15:8], data_byte};
        byte_position_next   = '0;
        phase_next = (bytes_remaining_next == 16'd0) ? tsd_pkg::PH_TYPE_HI
                                                     : tsd_pkg::PH_VALUE;
      end
      tsd_pkg::PH_VALUE: begin
        if (tsd_pkg::is_emitted(record_type)) begin
          emit                = 1'b1;
          result.record_kind  = tsd_pkg::kind_of(record_type);
          result.value_byte   = data_byte;
          result.value_offset = byte_position;
          result.value_last   = (bytes_remaining == 16'd1);
        end
        bytes_remaining_next = bytes_remaining - 16'd1;
        byte_position_next   = byte_position + 16'd1;
        if (bytes_remaining_next == 16'd0) begin
          phase_next = tsd_pkg::PH_TYPE_HI;
        end
      end
      default: begin
        record_type_next     = {data_byte, 8'h00};
        bytes_remaining_next = '0;
        byte_position_next   = '0;
        phase_next           = tsd_pkg::PH_TYPE_LO;
      end
    endcase

    if (end_of_stream) begin
      if (phase_next != tsd_pkg::PH_TYPE_HI) begin
        emit              = 1'b1;
        result.value_last = 1'b0;
        result.truncated  = 1'b1;
      end
      phase_next           = tsd_pkg::PH_TYPE_HI;
      record_type_next     = '0;
      bytes_remaining_next = '0;
      byte_position_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= tsd_pkg::PH_TYPE_HI;
      record_type     <= '0;
      bytes_remaining <= '0;
      byte_position   <= '0;
    end else if (step) begin
      phase           <= phase_next;
      record_type     <= record_type_next;
      bytes_remaining <= bytes_remaining_next;
      byte_position   <= byte_position_next;
    end
  end

endmodule

// ===== design/tsd_out_reg.sv =====
// ----------------------------------------------------------------------------
// TLV deframer result register
// Holds one result word for the downstream side and reports when it can take
// the next one.
// ----------------------------------------------------------------------------
module tsd_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  tsd_pkg::result_t result,
  output logic             free,
  tsd_out_if.source        record
);

  tsd_pkg::result_t held;

  assign free                = !record.valid || record.ready;
  assign record.record_kind  = held.record_kind;
  assign record.value_byte   = held.value_byte;
  assign record.value_offset = held.value_offset;
  assign record.value_last   = held.value_last;
  assign record.truncated    = held.truncated;

  always_ff @(posedge clk) begin
    if (rst) begin
      record.valid <= 1'b0;
    end else if (load) begin
      record.valid <= 1'b1;
    end else if (record.ready) begin
      record.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// TLV stream deframer testbench
// Drives byte streams into the deframer: a directed table of records first,
// then random well-formed records, truncated streams and noise. The table
// holds its own expected words, a parser predicts the rest, and each accepted
// word is matched field by field to the oldest. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int ITEMS_TOTAL = 1650;
  localparam logic [15:0] TYPE_ETH_FRAME = 16'h000A;
  localparam logic [15:0] TYPE_UNKNOWN   = 16'h000F;

  typedef enum logic [1:0] {
    CHK_PREDICT,
    CHK_NONE,
    CHK_WORD
  } row_check_t;

  typedef struct {
    logic [7:0]       data;
    logic             eos;
    row_check_t       check;
    tsd_pkg::result_t want;
  } stim_row_t;

  logic clk;
  logic rst;

  tsd_in_if  byte_ch ();
  tsd_out_if word_ch ();

  tlv_stream_deframer_top DUT (
    .clk    (clk),
    .rst    (rst),
    .stream (byte_ch),
    .record (word_ch)
  );

  tsd_pkg::phase_t ps_phase;
  logic [15:0]     ps_type;
  logic [15:0]     ps_left;
  logic [15:0]     ps_pos;

  tsd_pkg::result_t expected_words[$];
  int               errors;
  int               items_sent;
  int               sink_stall;
  bit               quiet;

  stim_row_t dir_rows [0:25] = '{
    '{8'h00, 1'b0, CHK_NONE, '0},
    '{8'h0C, 1'b0, CHK_NONE, '0},
    '{8'h00, 1'b0, CHK_NONE, '0},
    '{8'h02, 1'b0, CHK_NONE, '0},
    '{8'hFF, 1'b0, CHK_WORD, '{tsd_pkg::KIND_MAC_HEADER, 8'hFF, 16'd0, 1'b0, 1'b0}},
    '{8'h00, 1'b0, CHK_WORD, '{tsd_pkg::KIND_MAC_HEADER, 8'h00, 16'd1, 1'b1, 1'b0}},
    '{8'h00, 1'b0, CHK_NONE, '0},
    '{8'h0B, 1'b0, CHK_NONE, '0},
    '{8'h00, 1'b0, CHK_NONE, '0},
    '{8'h00, 1'b1, CHK_NONE, '0},
    '{8'h00, 1'b0, CHK_NONE, '0},
    '{8'h0B, 1'b0, CHK_NONE, '0},
    '{8'h00, 1'b0, CHK_NONE, '0},
    '{8'h01, 1'b0, CHK_NONE, '0},
    '{8'hA5, 1'b0, CHK_WORD, '{tsd_pkg::KIND_IP_CLIENT, 8'hA5, 16'd0, 1'b1, 1'b0}},
    '{8'h00, 1'b0, CHK_NONE, '0},
    '{8'h0F, 1'b0, CHK_NONE, '0},
    '{8'h00, 1'b0, CHK_NONE, '0},
    '{8'h01, 1'b0, CHK_NONE, '0},
    '{8'h5A, 1'b1, CHK_NONE, '0},
    '{8'h00, 1'b0, CHK_NONE, '0},
    '{8'h0D, 1'b0, CHK_NONE, '0},
    '{8'hFF, 1'b0, CHK_NONE, '0},
    '{8'hFF, 1'b0, CHK_NONE, '0},
    '{8'h3C, 1'b1, CHK_WORD, '{tsd_pkg::KIND_BUFFER, 8'h3C, 16'd0, 1'b0, 1'b1}},
    '{8'h00, 1'b1, CHK_WORD, '{tsd_pkg::KIND_MAC_HEADER, 8'h00, 16'd0, 1'b0, 1'b1}}
  };

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_parser();
    ps_phase = tsd_pkg::PH_TYPE_HI;
    ps_type  = '0;
    ps_left  = '0;
    ps_pos   = '0;
  endfunction

  // Advances the local parser by one stream byte and returns 1 when the byte
  // produces an output word.
  function automatic bit deframe_byte(input logic [7:0] b, input logic eos,
                                      output tsd_pkg::result_t word);
    bit               hit;
    logic [1:0]       kind;
    tsd_pkg::result_t w;
    hit  = 1'b0;
    kind = tsd_pkg::KIND_MAC_HEADER;
    w    = '0;
    case (ps_phase)
      tsd_pkg::PH_TYPE_LO: begin
        ps_type[7:0] = b;
        ps_phase = tsd_pkg::PH_LEN_HI;
      end
      tsd_pkg::PH_LEN_HI: begin
        ps_left = {b, 8'h00};
        ps_phase = tsd_pkg::PH_LEN_LO;
      end
      tsd_pkg::PH_LEN_LO: begin
        ps_left[7:0] = b;
        ps_pos = '0;
        ps_phase = (ps_left == 16'd0) ? tsd_pkg::PH_TYPE_HI : tsd_pkg::PH_VALUE;
      end
      tsd_pkg::PH_VALUE: begin
        hit = 1'b1;
        case (ps_type)
          tsd_pkg::TYPE_MAC_HEADER: kind = tsd_pkg::KIND_MAC_HEADER;
          tsd_pkg::TYPE_IP_CLIENT:  kind = tsd_pkg::KIND_IP_CLIENT;
          tsd_pkg::TYPE_BUFFER:     kind = tsd_pkg::KIND_BUFFER;
          default:                  hit = 1'b0;
        endcase
        if (hit) begin
          w = '{kind, b, ps_pos, ps_left == 16'd1, 1'b0};
        end
        ps_left = ps_left - 16'd1;
        ps_pos  = ps_pos + 16'd1;
        if (ps_left == 16'd0) begin
          ps_phase = tsd_pkg::PH_TYPE_HI;
        end
      end
      default: begin
        ps_type  = {b, 8'h00};
        ps_left  = '0;
        ps_pos   = '0;
        ps_phase = tsd_pkg::PH_TYPE_LO;
      end
    endcase
    if (eos) begin
      if (ps_phase != tsd_pkg::PH_TYPE_HI) begin
        w.value_last = 1'b0;
        w.truncated  = 1'b1;
        hit = 1'b1;
      end
      clear_parser();
    end
    word = w;
    return hit;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eos,
                           input row_check_t chk, input tsd_pkg::result_t want);
    tsd_pkg::result_t guess;
    bit               hit;
    int               gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 11);
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid         <= 1'b1;
    byte_ch.data_byte     <= b;
    byte_ch.end_of_stream <= eos;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    hit = deframe_byte(b, eos, guess);
    case (chk)
      CHK_PREDICT: if (hit) expected_words = {expected_words, guess};
      CHK_WORD:    expected_words = {expected_words, want};
      default: ;
    endcase
    items_sent++;
    if (items_sent > ITEMS_TOTAL - 300) begin
      quiet = 1'b1;
    end
  endtask

  task automatic send_random_record();
    logic [15:0] rtype;
    logic [15:0] rlen;
    logic [7:0]  b;
    int          total;
    int          cut;
    int          pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1, 2: rtype = tsd_pkg::TYPE_MAC_HEADER;
      3, 4:    rtype = tsd_pkg::TYPE_IP_CLIENT;
      5, 6:    rtype = tsd_pkg::TYPE_BUFFER;
      7:       rtype = TYPE_ETH_FRAME;
      8:       rtype = TYPE_UNKNOWN;
      default: rtype = 16'($urandom);
    endcase
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      rlen = 16'd0;
    end else if (pick <= 15) begin
      rlen = 16'($urandom_range(1, 8));
    end else if (pick <= 17) begin
      rlen = 16'($urandom_range(9, 40));
    end else if (pick == 18) begin
      rlen = 16'($urandom_range(200, 300));
    end else begin
      rlen = 16'($urandom);
    end
    total = 4 + int'(rlen);
    cut = -1;
    pick = $urandom_range(0, 15);
    if (rlen > 16'd300) begin
      cut = $urandom_range(0, 24);
    end else if (pick == 0) begin
      cut = $urandom_range(0, total - 1);
    end else if (pick <= 2) begin
      cut = total - 1;
    end
    for (int i = 0; i < total; i++) begin
      case (i)
        0:       b = rtype[15:8];
        1:       b = rtype[7:0];
        2:       b = rlen[15:8];
        3:       b = rlen[7:0];
        default: b = 8'($urandom);
      endcase
      send_byte(b, i == cut, CHK_PREDICT, '0);
      if (i == cut) break;
    end
  endtask

  // Random bytes that break the framing; the last one ends the stream so
  // the parser starts clean afterwards.
  task automatic send_noise();
    int n;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      send_byte(8'($urandom), (i == n - 1) || ($urandom_range(0, 5) == 0), CHK_PREDICT,
                '0);
    end
  endtask

  always @(posedge clk) begin : word_sink
    tsd_pkg::result_t got;
    tsd_pkg::result_t want;
    if (rst) begin
      word_ch.ready <= 1'b0;
    end else begin
      if (word_ch.valid && word_ch.ready) begin
        got = '{word_ch.record_kind, word_ch.value_byte, word_ch.value_offset,
                word_ch.value_last, word_ch.truncated};
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word %h", $time, got);
          errors++;
        end else begin
          want = expected_words.pop_front();
          if (got.record_kind != want.record_kind) begin
            $display("%0t: record_kind expected %0d actual %0d", $time,
                     want.record_kind, got.record_kind);
            errors++;
          end
          if (got.value_byte != want.value_byte) begin
            $display("%0t: value_byte expected %h actual %h", $time,
                     want.value_byte, got.value_byte);
            errors++;
          end
          if (got.value_offset != want.value_offset) begin
            $display("%0t: value_offset expected %0d actual %0d", $time,
                     want.value_offset, got.value_offset);
            errors++;
          end
          if (got.value_last != want.value_last) begin
            $display("%0t: value_last expected %b actual %b", $time,
                     want.value_last, got.value_last);
            errors++;
          end
          if (got.truncated != want.truncated) begin
            $display("%0t: truncated expected %b actual %b", $time,
                     want.truncated, got.truncated);
            errors++;
          end
        end
      end
      if (sink_stall > 0) begin
        sink_stall = sink_stall - 1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        sink_stall = $urandom_range(1, 11);
      end
      word_ch.ready <= (sink_stall == 0);
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    byte_ch.valid = 1'b0;
    byte_ch.data_byte = '0;
    byte_ch.end_of_stream = 1'b0;
    word_ch.ready = 1'b0;
    errors = 0;
    items_sent = 0;
    sink_stall = 0;
    quiet = 1'b0;
    clear_parser();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].data, dir_rows[i].eos, dir_rows[i].check, dir_rows[i].want);
    end
    while (items_sent < ITEMS_TOTAL) begin
      if ($urandom_range(0, 9) == 0) begin
        send_noise();
      end else begin
        send_random_record();
      end
    end
    byte_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("[tlv_stream_deframer_top] OK");
    end else begin
      $display("[tlv_stream_deframer_top] ERROR");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("[tlv_stream_deframer_top] ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/tsd_pkg.sv
design/tsd_stream_ifs.sv
design/tsd_in_reg.sv
design/tsd_parse_core.sv
design/tsd_out_reg.sv
design/tlv_stream_deframer_top.sv
dv/tb_top.sv
